// ----- design/quoted_word_tokenizer_defines.svh -----
// assertion macros shared by the tokenizer
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

// condition implies consequence in the same cycle
`define QWT_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("tokenizer check failed");

// condition implies consequence in the next cycle
`define QWT_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("tokenizer check failed");

`endif

// ----- design/qwt_pkg.sv -----
package qwt_pkg;

   // default depth of the queue between front and back
   localparam int QWT_QUEUE_DEPTH = 4;

   // special bytes
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_END    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_EOW  = 2'd1,
      KIND_EOL  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_PLAIN  = 4'b0010,
      MODE_QUOTED = 4'b0100,
      MODE_ESCAPE = 4'b1000
   } mode_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
   } result_type;

   // one queued entry: one or two results from a single byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } op_type;

   // queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic result_type mk_char(input logic [7:0] c);
      mk_char.kind = KIND_CHAR;
      mk_char.ch   = c;
   endfunction

   function automatic result_type mk_mark(input kind_type k);
      mk_mark.kind = k;
      mk_mark.ch   = 8'h00;
   endfunction

endpackage

// ----- design/qwt_front.sv -----
module qwt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_ch,
   input  qwt_pkg::qstat_type qstat,
   output logic              push,
   output qwt_pkg::op_type   push_op
);
   import qwt_pkg::*;

   mode_type mode_ff, mode_in;
   logic     accept;
   logic     has_out;
   op_type   op;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   // classify the byte against the current mode
   always_comb begin
      mode_in = mode_ff;
      has_out = 1'b0;
      op.two  = 1'b0;
      op.r0   = mk_mark(KIND_EOW);
      op.r1   = mk_mark(KIND_EOL);
      case (mode_ff)
         MODE_IDLE: begin
            if (req_ch == CH_END) begin
               has_out = 1'b1;
               op.r0   = mk_mark(KIND_EOL);
            end else if (is_blank(req_ch)) begin
               has_out = 1'b0;
            end else if (req_ch == CH_QUOTE) begin
               mode_in = MODE_QUOTED;
            end else begin
               has_out = 1'b1;
               op.r0   = mk_char(req_ch);
               mode_in = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            has_out = 1'b1;
            if (req_ch == CH_END) begin
               op.two  = 1'b1;
               mode_in = MODE_IDLE;
            end else if (is_blank(req_ch)) begin
               mode_in = MODE_IDLE;
            end else begin
               op.r0 = mk_char(req_ch);
            end
         end
         MODE_QUOTED: begin
            if (req_ch == CH_END) begin
               has_out = 1'b1;
               op.two  = 1'b1;
               mode_in = MODE_IDLE;
            end else if (req_ch == CH_BSLASH) begin
               mode_in = MODE_ESCAPE;
            end else if (req_ch == CH_QUOTE) begin
               has_out = 1'b1;
               mode_in = MODE_IDLE;
            end else begin
               has_out = 1'b1;
               op.r0   = mk_char(req_ch);
            end
         end
         MODE_ESCAPE: begin
            has_out = 1'b1;
            if (req_ch == CH_END) begin
               op.two  = 1'b1;
               mode_in = MODE_IDLE;
            end else if ((req_ch == CH_QUOTE) || (req_ch == CH_BSLASH)) begin
               op.r0   = mk_char(req_ch);
               mode_in = MODE_QUOTED;
            end else begin
               op.two  = 1'b1;
               op.r0   = mk_char(CH_BSLASH);
               op.r1   = mk_char(req_ch);
               mode_in = MODE_QUOTED;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase
   end

   assign push    = accept && has_out;
   assign push_op = op;

   // mode register advances on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ----- design/qwt_queue.sv -----
module qwt_queue #(
   parameter int Depth = qwt_pkg::QWT_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qwt_pkg::op_type    push_op,
   input  logic               pop,
   output qwt_pkg::op_type    head_op,
   output qwt_pkg::qstat_type qstat
);
   import qwt_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   op_type            entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == CntW'(Depth));
   assign qstat.empty = (count_ff == '0);
   assign head_op     = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- design/qwt_back.sv -----
module qwt_back (
   input  logic               clock,
   input  logic               reset,
   input  qwt_pkg::op_type    head_op,
   input  qwt_pkg::qstat_type qstat,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_last
);
   import qwt_pkg::*;

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   result_type res_ff, res_in;
   logic       last_ff, last_in;
   logic       load;

   // output register is free when empty or being taken
   assign load = !qstat.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         res_in   = phase_ff ? head_op.r1 : head_op.r0;
         if (phase_ff || !head_op.two) begin
            last_in  = 1'b1;
            pop      = 1'b1;
            phase_in = 1'b0;
         end else begin
            last_in  = 1'b0;
            phase_in = 1'b1;
         end
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = res_ff.kind;
   assign rsp_out_char = res_ff.ch;
   assign rsp_last     = last_ff;

endmodule

// ----- design/quoted_word_tokenizer.sv -----
// path: a byte's results are registered in the queue, then in the output register
// throughput: one byte per cycle; a byte with two results holds the output for both in turn,
//   the queue between front and back absorbs that, input stalls only when it is full
// reset: synchronous, clears the word mode, the queue and the output valid and phase flags
`include "quoted_word_tokenizer_defines.svh"
module quoted_word_tokenizer #(
   parameter int QueueDepth = qwt_pkg::QWT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last
);
   import qwt_pkg::*;

   qstat_type qstat;
   op_type    push_op;
   op_type    head_op;
   logic      push;
   logic      pop;

   // classify bytes and track the word mode
   qwt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .qstat     (qstat),
      .push      (push),
      .push_op   (push_op)
   );

   // decoupling queue
   qwt_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .qstat   (qstat)
   );

   // emit results one per cycle while results are queued and the output is not stalled
   qwt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_op      (head_op),
      .qstat        (qstat),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   // end of line is always the final result of its byte
   `QWT_ASSERT_NOW(a_eol_last, clock, reset, rsp_valid && (rsp_kind == KIND_EOL), rsp_last)
   // marks carry no character
   `QWT_ASSERT_NOW(a_mark_zero, clock, reset, rsp_valid && (rsp_kind != KIND_CHAR),
      rsp_out_char == 8'h00)
   // the partner of a non-final result follows at once
   `QWT_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && !rsp_last && !rsp_stall,
      rsp_valid)
   // a push never meets a full queue
   `QWT_ASSERT_NOW(a_no_overflow, clock, reset, qstat.full, !push)

endmodule
